FILE: design/sbct_pkg.sv
// package for the swept box collision test
// holds the command codes, time constants, default widths and back-end state type; depends on nothing
`default_nettype none
package sbct_pkg;
    localparam int ID_BITS_DEF    = 8;
    localparam int COORD_BITS_DEF = 32;
    localparam int TOL_BITS       = 16;
    localparam int TIME_BITS      = 32;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd256;
    localparam logic signed [TIME_BITS-1:0] TIME_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TIME_BITS-1:0] TIME_MIN = 32'sh8000_0000;
    localparam logic signed [TIME_BITS-1:0] TIME_ONE = 32'sh0001_0000;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef enum logic [2:0] {
        BK_IDLE, BK_DIV_START, BK_DIV_WAIT, BK_DEEP_START, BK_DEEP_WAIT, BK_DONE
    } bk_state_t;
endpackage
`default_nettype wire

FILE: design/sbct_div.sv
// iterative unsigned divider, one quotient bit per cycle
// standalone, depends on nothing; quotient has NW bits, done pulses one cycle
`default_nettype none
module sbct_div #(
    parameter int NW = 64,
    parameter int DW = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        trial = '0;
        if (start) begin
            q_next = num; r_next = '0; d_next = den;
            cnt_next = CW'(NW); busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {r_reg[DW-1:0], q_reg[NW-1]};
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

FILE: design/sbct_front.sv
// front end: accepts items, keeps the mover, forms relative velocities and edge gaps
// depends on sbct_pkg; feeds a two-entry queue to the back end
`default_nettype none
module sbct_front #(
    parameter int ID_BITS    = sbct_pkg::ID_BITS_DEF,
    parameter int COORD_BITS = sbct_pkg::COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_cmd,
    input  wire logic signed [COORD_BITS-1:0] s_box_min_x,
    input  wire logic signed [COORD_BITS-1:0] s_box_min_y,
    input  wire logic signed [COORD_BITS-1:0] s_box_max_x,
    input  wire logic signed [COORD_BITS-1:0] s_box_max_y,
    input  wire logic signed [COORD_BITS-1:0] s_vel_x,
    input  wire logic signed [COORD_BITS-1:0] s_vel_y,
    input  wire logic [ID_BITS-1:0]           s_obstacle_id,
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output logic [6*(COORD_BITS+1)+ID_BITS:0] q_data
);
    import sbct_pkg::*;
    localparam int GW = COORD_BITS + 1;
    localparam int EW = 6*GW + ID_BITS + 1;
    logic signed [COORD_BITS-1:0] mnx_reg, mny_reg, mxx_reg, mxy_reg, mvx_reg, mvy_reg;
    logic [EW-1:0] ent_reg [2];
    logic [1:0]    cnt_reg;
    logic          wp_reg, rp_reg;
    logic          push, pop;
    logic signed [GW-1:0] rvx, rvy, ax, bx, ay, by;
    logic [EW-1:0] ent;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = ent_reg[rp_reg];

    // gaps: entry numerator a = omin - mmax, b = omax - mmin
    always_comb begin
        rvx = GW'(mvx_reg) - GW'(s_vel_x);
        rvy = GW'(mvy_reg) - GW'(s_vel_y);
        ax  = GW'(s_box_min_x) - GW'(mxx_reg);
        bx  = GW'(s_box_max_x) - GW'(mnx_reg);
        ay  = GW'(s_box_min_y) - GW'(mxy_reg);
        by  = GW'(s_box_max_y) - GW'(mny_reg);
        ent = {s_cmd, rvx, rvy, ax, bx, ay, by, s_obstacle_id};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; wp_reg <= 1'b0; rp_reg <= 1'b0;
            mnx_reg <= '0; mny_reg <= '0; mxx_reg <= '0;
            mxy_reg <= '0; mvx_reg <= '0; mvy_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
                if (s_cmd == CMD_LOAD) begin
                    mnx_reg <= s_box_min_x; mny_reg <= s_box_min_y;
                    mxx_reg <= s_box_max_x; mxy_reg <= s_box_max_y;
                    mvx_reg <= s_vel_x;     mvy_reg <= s_vel_y;
                end
            end
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) ent_reg[wp_reg] <= ent;
    end
endmodule
`default_nettype wire

FILE: design/sbct_back.sv
// back end: time divisions on one shared divider, rejection tests, best-hit record
// depends on sbct_pkg and sbct_div
`default_nettype none
module sbct_back #(
    parameter int ID_BITS    = sbct_pkg::ID_BITS_DEF,
    parameter int COORD_BITS = sbct_pkg::COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [sbct_pkg::TOL_BITS-1:0] tol,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire logic [6*(COORD_BITS+1)+ID_BITS:0] q_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_hit,
    output logic signed [31:0]                m_entry_time,
    output logic                              m_hit_on_x,
    output logic                              m_best_valid,
    output logic signed [31:0]                m_best_time,
    output logic [ID_BITS-1:0]                m_best_id,
    output logic                              m_best_on_x
);
    import sbct_pkg::*;
    localparam int GW = COORD_BITS + 1;
    // dividend is |gap| << 16; quotient above 31 bits saturates
    localparam int NW = GW + 16;
    localparam int DW = GW;

    bk_state_t state_reg, state_next;
    logic [6*GW+ID_BITS:0] e_reg;
    logic [1:0] k_reg, k_next;          // which division: ax, bx, ay, by
    logic signed [31:0] t_reg [4];
    logic signed [31:0] en_reg, en_next;
    logic onx_reg, onx_next, kd_reg, kd_next;
    logic deep_reg, deep_next;
    logic ov_reg, hit_reg, onxo_reg;
    logic signed [31:0] ent_o_reg;
    logic bvalid_reg, bonx_reg;
    logic signed [31:0] btime_reg;
    logic [ID_BITS-1:0] bid_reg;

    logic cmd;
    logic signed [GW-1:0] rvx, rvy, g [4];
    logic [ID_BITS-1:0] oid;
    assign cmd = e_reg[6*GW+ID_BITS];
    assign rvx = e_reg[ID_BITS+6*GW-1 -: GW];
    assign rvy = e_reg[ID_BITS+5*GW-1 -: GW];
    assign g[0] = e_reg[ID_BITS+4*GW-1 -: GW];
    assign g[1] = e_reg[ID_BITS+3*GW-1 -: GW];
    assign g[2] = e_reg[ID_BITS+2*GW-1 -: GW];
    assign g[3] = e_reg[ID_BITS+GW-1 -: GW];
    assign oid = e_reg[ID_BITS-1:0];

    logic div_start, div_done;
    logic [NW-1:0] div_num, div_q;
    logic [DW-1:0] div_den;
    sbct_div #(.NW(NW), .DW(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quot(div_q)
    );

    function automatic logic [GW-1:0] magf(input logic signed [GW-1:0] x);
        magf = x[GW-1] ? GW'(-x) : GW'(x);
    endfunction

    logic signed [GW-1:0] cur_v, cur_g, dv;
    logic neg;
    logic signed [31:0] tq, xen, xex, yen, yex, exitt, entry;
    logic ovx, ovy, xon;

    always_comb begin
        cur_v = k_reg[1] ? rvy : rvx;
        cur_g = g[k_reg];
        neg   = cur_g[GW-1] ^ cur_v[GW-1];
        if (div_q[NW-1:31] != '0) tq = neg ? TIME_MIN : TIME_MAX;
        else tq = neg ? -$signed({1'b0, div_q[30:0]}) : $signed({1'b0, div_q[30:0]});
        // zero-velocity axes: strict overlap means b > 0 and a < 0
        ovx = (g[1] > 0) && (g[0] < 0);
        ovy = (g[3] > 0) && (g[2] < 0);
        if (rvx == 0) begin
            xen = ovx ? TIME_MIN : TIME_MAX; xex = ovx ? TIME_MAX : TIME_MIN;
        end else if (rvx[GW-1]) begin
            xen = t_reg[1]; xex = t_reg[0];
        end else begin
            xen = t_reg[0]; xex = t_reg[1];
        end
        if (rvy == 0) begin
            yen = ovy ? TIME_MIN : TIME_MAX; yex = ovy ? TIME_MAX : TIME_MIN;
        end else if (rvy[GW-1]) begin
            yen = t_reg[3]; yex = t_reg[2];
        end else begin
            yen = t_reg[2]; yex = t_reg[3];
        end
        xon   = xen > yen;
        entry = xon ? xen : yen;
        exitt = (xex < yex) ? xex : yex;
        dv    = kd_reg ? rvy : rvx;
    end

    logic [31:0] mag_en;
    assign mag_en = en_reg[31] ? 32'(-en_reg) : 32'(en_reg);

    always_comb begin
        state_next = state_reg; k_next = k_reg; en_next = en_reg;
        onx_next = onx_reg; kd_next = kd_reg; deep_next = deep_reg;
        div_start = 1'b0; div_num = '0; div_den = '0;
        q_ready = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                q_ready = !ov_reg;
                if (q_valid && !ov_reg) begin
                    state_next = BK_DIV_START;
                    k_next = '0; kd_next = 1'b0; deep_next = 1'b0;
                end
            end
            BK_DIV_START: begin
                if (cmd == CMD_LOAD) state_next = BK_DONE;
                else if (cur_v == 0) begin
                    if (k_reg == 2'd3) state_next = BK_DEEP_START;
                    k_next = k_reg + 2'd1;
                end else begin
                    div_start = 1'b1;
                    div_num = {magf(cur_g), 16'd0};
                    div_den = magf(cur_v);
                    state_next = BK_DIV_WAIT;
                end
            end
            BK_DIV_WAIT: begin
                if (div_done) begin
                    k_next = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? BK_DEEP_START : BK_DIV_START;
                end
            end
            BK_DEEP_START: begin
                // first pass latches entry; then checks x then y depth
                en_next = entry; onx_next = xon;
                if (dv == 0 || entry >= 0) begin
                    if (kd_reg) state_next = BK_DONE;
                    kd_next = 1'b1;
                end else begin
                    div_start = 1'b1;
                    div_num = NW'({tol, 16'd0});
                    div_den = magf(dv);
                    state_next = BK_DEEP_WAIT;
                end
            end
            BK_DEEP_WAIT: begin
                if (div_done) begin
                    if ({{(NW-32){1'b0}}, mag_en} > div_q) deep_next = 1'b1;
                    if (kd_reg) state_next = BK_DONE;
                    else state_next = BK_DEEP_START;
                    kd_next = 1'b1;
                end
            end
            BK_DONE: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    logic fin_hit;
    assign fin_hit = !(en_reg > exitt || (rvx == 0 && rvy == 0) || deep_reg ||
                       en_reg > TIME_ONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE; k_reg <= '0; kd_reg <= 1'b0; deep_reg <= 1'b0;
            ov_reg <= 1'b0; bvalid_reg <= 1'b0; btime_reg <= TIME_MAX;
            bid_reg <= '0; bonx_reg <= 1'b0;
        end else begin
            state_reg <= state_next; k_reg <= k_next;
            kd_reg <= kd_next; deep_reg <= deep_next;
            if (state_reg == BK_DONE) ov_reg <= 1'b1;
            else if (m_valid && m_ready) ov_reg <= 1'b0;
            if (state_reg == BK_DONE) begin
                if (cmd == CMD_LOAD) begin
                    bvalid_reg <= 1'b0; btime_reg <= TIME_MAX;
                    bid_reg <= '0; bonx_reg <= 1'b0;
                end else if (fin_hit && en_reg < btime_reg) begin
                    bvalid_reg <= 1'b1; btime_reg <= en_reg;
                    bid_reg <= oid; bonx_reg <= onx_reg;
                end
            end
        end
        if (state_reg == BK_IDLE && q_valid && !ov_reg) e_reg <= q_data;
        if (state_reg == BK_DIV_WAIT && div_done) t_reg[k_reg] <= tq;
        en_reg <= en_next; onx_reg <= onx_next;
        if (state_reg == BK_DONE) begin
            hit_reg   <= (cmd == CMD_TEST) && fin_hit;
            ent_o_reg <= (cmd == CMD_TEST) ? en_reg : '0;
            onxo_reg  <= (cmd == CMD_TEST) && onx_reg;
        end
    end

    assign m_valid      = ov_reg;
    assign m_hit        = hit_reg;
    assign m_entry_time = ent_o_reg;
    assign m_hit_on_x   = onxo_reg;
    assign m_best_valid = bvalid_reg;
    assign m_best_time  = btime_reg;
    assign m_best_id    = bid_reg;
    assign m_best_on_x  = bonx_reg;
endmodule
`default_nettype wire

FILE: design/swept_box_collision_test.sv
// top level of the swept box collision test
// depends on sbct_pkg, sbct_front, sbct_back, sbct_div
//
// channel   ports                       direction
// s_        s_valid/s_ready + box, vel   in
// m_        m_valid/m_ready + hit, best  out
// cfg_      cfg_valid/cfg_ready + data   in
//
// the back end takes one transaction at a time; a load goes from the queue through BK_DIV_START
// and BK_DONE to its result without a division. each division uses the shared divider; a test
// runs up to four time divisions and two depth divisions, and none when both velocities match.
// reset is synchronous, active low, and needs no clearing pass.
// a two-entry queue lets the input side run ahead while the back end or m_ready stalls.
`default_nettype none
module swept_box_collision_test #(
    parameter int ID_BITS    = sbct_pkg::ID_BITS_DEF,
    parameter int COORD_BITS = sbct_pkg::COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [sbct_pkg::TOL_BITS-1:0] cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_cmd,
    input  wire logic signed [COORD_BITS-1:0] s_box_min_x,
    input  wire logic signed [COORD_BITS-1:0] s_box_min_y,
    input  wire logic signed [COORD_BITS-1:0] s_box_max_x,
    input  wire logic signed [COORD_BITS-1:0] s_box_max_y,
    input  wire logic signed [COORD_BITS-1:0] s_vel_x,
    input  wire logic signed [COORD_BITS-1:0] s_vel_y,
    input  wire logic [ID_BITS-1:0]           s_obstacle_id,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_hit,
    output logic signed [31:0]                m_entry_time,
    output logic                              m_hit_on_x,
    output logic                              m_best_valid,
    output logic signed [31:0]                m_best_time,
    output logic [ID_BITS-1:0]                m_best_id,
    output logic                              m_best_on_x
);
    import sbct_pkg::*;
    logic [TOL_BITS-1:0] tol_reg;
    logic q_valid, q_ready;
    logic [6*(COORD_BITS+1)+ID_BITS:0] q_data;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) tol_reg <= TOL_RESET;
        else if (cfg_valid && cfg_ready) tol_reg <= cfg_data;
    end

    sbct_front #(.ID_BITS(ID_BITS), .COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_box_min_x(s_box_min_x), .s_box_min_y(s_box_min_y),
        .s_box_max_x(s_box_max_x), .s_box_max_y(s_box_max_y),
        .s_vel_x(s_vel_x), .s_vel_y(s_vel_y), .s_obstacle_id(s_obstacle_id),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    sbct_back #(.ID_BITS(ID_BITS), .COORD_BITS(COORD_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .tol(tol_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_entry_time(m_entry_time), .m_hit_on_x(m_hit_on_x),
        .m_best_valid(m_best_valid), .m_best_time(m_best_time),
        .m_best_id(m_best_id), .m_best_on_x(m_best_on_x)
    );
endmodule
`default_nettype wire
